>>> src/smsd_pkg.sv
// Shared types and constants for the sliding-median spike detector.
// Used by smsd_hist, smsd_rank_scan and sliding_median_spike_detector.
package smsd_pkg;

    localparam int WINDOW_MAX   = 1024;
    localparam int VALUE_LEVELS = 256;

    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int LEN_W   = PTR_W + 1;
    localparam int VAL_W   = $clog2(VALUE_LEVELS);
    localparam int CNT_W   = LEN_W;
    localparam int RANK_W  = PTR_W;
    localparam int MED_W   = VAL_W + 1;
    localparam int ALERT_W = 32;

    localparam int IN_DATA_W  = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 + MED_W + ALERT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [VAL_W-1:0] rd_addr;
        logic             wr_en;
        logic [VAL_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } hist_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] va;
        logic [VAL_W-1:0] vb;
    } scan_stat_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DEC_RD = 8'b0000_1000,
        S_DEC_WR = 8'b0001_0000,
        S_INC_RD = 8'b0010_0000,
        S_INC_WR = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

endpackage

>>> src/smsd_hist.sv
// Per-value histogram memory with one write and one registered read port.
// A valid bit per bin makes a cleared bin read as zero. Depends on smsd_pkg.
module smsd_hist (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  smsd_pkg::hist_req_t        req,
    output logic [smsd_pkg::CNT_W-1:0] rd_count
);
    import smsd_pkg::*;

    logic [CNT_W-1:0]        hist_mem [VALUE_LEVELS];
    logic [VALUE_LEVELS-1:0] valid_reg;
    logic [CNT_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            hist_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= hist_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/smsd_rank_scan.sv
// Rank search over histogram bins: accumulates bin counts one bin per cycle while live
// is high and records the values at two sorted ranks. Depends on smsd_pkg.
module smsd_rank_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        live,
    input  logic [smsd_pkg::VAL_W-1:0]  tag,
    input  logic [smsd_pkg::CNT_W-1:0]  count,
    input  logic [smsd_pkg::RANK_W-1:0] rank_a,
    input  logic [smsd_pkg::RANK_W-1:0] rank_b,
    output smsd_pkg::scan_stat_t        stat
);
    import smsd_pkg::*;

    localparam logic [VAL_W-1:0] TOP_BIN = VAL_W'(VALUE_LEVELS - 1);

    logic [CNT_W:0]   acc_reg;
    logic [CNT_W:0]   acc_next;
    logic             a_found_reg;
    logic             done_reg;
    logic [VAL_W-1:0] va_reg;
    logic [VAL_W-1:0] vb_reg;
    logic             hit_a;
    logic             hit_b;

    assign acc_next = acc_reg + {1'b0, count};
    assign hit_a    = acc_next > (CNT_W + 1)'(rank_a);
    assign hit_b    = acc_next > (CNT_W + 1)'(rank_b);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            acc_reg     <= '0;
            a_found_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else if (live && !done_reg) begin
            acc_reg <= acc_next;
            if (hit_a || tag == TOP_BIN) begin
                a_found_reg <= 1'b1;
            end
            if (hit_b || tag == TOP_BIN) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (live && !done_reg) begin
            if (!a_found_reg && (hit_a || tag == TOP_BIN)) begin
                va_reg <= tag;
            end
            if (hit_b || tag == TOP_BIN) begin
                vb_reg <= tag;
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.va   = va_reg;
    assign stat.vb   = vb_reg;

endmodule

>>> src/sliding_median_spike_detector.sv
// Sliding-median spike detector, top level with the item sequencer and sample ring.
// While the window fills, an accepted sample passes S_LOAD, S_INC_RD, S_INC_WR and S_OUT;
// once it is full, S_SCAN over up to 256 bins, S_DEC_RD and S_DEC_WR come before S_INC_RD.
// A new sample is taken only in S_IDLE; S_OUT holds while a result waits on m_tready.
// Reset and clearing act on the valid bits of the histogram, which clear at once.
// Depends on smsd_pkg, smsd_hist and smsd_rank_scan.
module sliding_median_spike_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [smsd_pkg::LEN_W-1:0]      cfg_wr_data,   // window_length
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smsd_pkg::IN_DATA_W-1:0]  s_tdata,       // sample_value
    input  logic                            s_tuser,       // start_new
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // decided, alert, median_times_two, alert_count, zero padding
    output logic [smsd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import smsd_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);

    state_t               state_reg;
    state_t               state_next;
    logic [LEN_W-1:0]     wl_reg;
    logic [VAL_W-1:0]     sample_reg;
    logic [LEN_W-1:0]     fill_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [ALERT_W-1:0]   alert_total_reg;
    logic                 decided_reg;
    logic                 alert_reg;
    logic [MED_W-1:0]     med2_reg;
    logic [VAL_W:0]       scan_cnt_reg;
    logic                 live_reg;
    logic [VAL_W-1:0]     tag_reg;
    logic [VAL_W-1:0]     ring_rd_reg;
    logic [VAL_W-1:0]     ring_mem [WINDOW_MAX];
    logic                 m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [LEN_W-1:0]     len;
    logic [RANK_W-1:0]    rank_a;
    logic [RANK_W-1:0]    rank_b;
    logic                 accept;
    logic                 clear;
    logic                 issue;
    logic [MED_W-1:0]     med2_sum;
    logic [LEN_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     hist_count;
    hist_req_t            hreq;
    scan_stat_t           sstat;

    assign len = (wl_reg == '0) ? LEN_W'(1) : ((wl_reg > LEN_MAX) ? LEN_MAX : wl_reg);
    assign rank_b = len[LEN_W-1:1];
    assign rank_a = len[0] ? rank_b : rank_b - RANK_W'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign clear    = cfg_wr_en || (accept && s_tuser);
    assign issue    = (state_reg == S_SCAN) && !scan_cnt_reg[VAL_W] && !sstat.done;
    assign med2_sum = {1'b0, sstat.va} + {1'b0, sstat.vb};
    assign pos_inc  = {1'b0, ptr_reg} + LEN_W'(1);

    always_comb begin
        hreq = '0;
        hreq.clear = clear;
        case (state_reg)
            S_SCAN: begin
                hreq.rd_en   = issue;
                hreq.rd_addr = scan_cnt_reg[VAL_W-1:0];
            end
            S_DEC_RD: begin
                hreq.rd_en   = 1'b1;
                hreq.rd_addr = ring_rd_reg;
            end
            S_DEC_WR: begin
                hreq.wr_en   = 1'b1;
                hreq.wr_addr = ring_rd_reg;
                hreq.wr_data = (hist_count != '0) ? hist_count - CNT_W'(1) : hist_count;
            end
            S_INC_RD: begin
                hreq.rd_en   = 1'b1;
                hreq.rd_addr = sample_reg;
            end
            S_INC_WR: begin
                hreq.wr_en   = 1'b1;
                hreq.wr_addr = sample_reg;
                hreq.wr_data = hist_count + CNT_W'(1);
            end
            default: begin
                hreq.rd_en = 1'b0;
            end
        endcase
    end

    smsd_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (hreq),
        .rd_count (hist_count)
    );

    smsd_rank_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (state_reg == S_LOAD),
        .live    (live_reg),
        .tag     (tag_reg),
        .count   (hist_count),
        .rank_a  (rank_a),
        .rank_b  (rank_b),
        .stat    (sstat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                state_next = (fill_reg >= len) ? S_SCAN : S_INC_RD;
            end
            S_SCAN: begin
                if (sstat.done) begin
                    state_next = S_DEC_RD;
                end
            end
            S_DEC_RD: state_next = S_DEC_WR;
            S_DEC_WR: state_next = S_INC_RD;
            S_INC_RD: state_next = S_INC_WR;
            S_INC_WR: state_next = S_OUT;
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_INC_WR) begin
            ring_mem[ptr_reg] <= sample_reg;
        end
        if (state_reg == S_LOAD) begin
            ring_rd_reg <= ring_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_tdata[VAL_W-1:0];
        end
        tag_reg <= scan_cnt_reg[VAL_W-1:0];
        case (state_reg)
            S_LOAD: begin
                med2_reg <= '0;
            end
            S_DEC_RD: begin
                med2_reg <= med2_sum;
            end
            default: begin
                med2_reg <= med2_reg;
            end
        endcase
        if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= OUT_DATA_W'({alert_total_reg, med2_reg, alert_reg, decided_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            wl_reg          <= LEN_W'(1);
            fill_reg        <= '0;
            ptr_reg         <= '0;
            alert_total_reg <= '0;
            decided_reg     <= 1'b0;
            alert_reg       <= 1'b0;
            scan_cnt_reg    <= '0;
            live_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= issue;
            if (cfg_wr_en) begin
                wl_reg <= cfg_wr_data;
            end
            if (clear) begin
                fill_reg        <= '0;
                ptr_reg         <= '0;
                alert_total_reg <= '0;
            end
            case (state_reg)
                S_LOAD: begin
                    decided_reg  <= (fill_reg >= len);
                    alert_reg    <= 1'b0;
                    scan_cnt_reg <= '0;
                end
                S_SCAN: begin
                    if (issue) begin
                        scan_cnt_reg <= scan_cnt_reg + (VAL_W + 1)'(1);
                    end
                end
                S_DEC_RD: begin
                    if ({1'b0, sample_reg} >= med2_sum) begin
                        alert_reg <= 1'b1;
                        if (alert_total_reg != '1) begin
                            alert_total_reg <= alert_total_reg + ALERT_W'(1);
                        end
                    end
                end
                S_INC_WR: begin
                    if (!decided_reg) begin
                        fill_reg <= fill_reg + LEN_W'(1);
                    end
                    ptr_reg <= (pos_inc >= len) ? '0 : pos_inc[PTR_W-1:0];
                end
                default: begin
                    scan_cnt_reg <= scan_cnt_reg;
                end
            endcase
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> dv/sliding_median_spike_detector_test.sv
// Self-checking testbench for sliding_median_spike_detector: drives samples and window
// lengths, predicts every result in its own window model and compares each transaction.
// Depends on smsd_pkg and on the RTL of the block.
module sliding_median_spike_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smsd_pkg::*;

    typedef struct packed {
        logic [ALERT_W-1:0] count;
        logic [MED_W-1:0]   med2;
        logic               alert;
        logic               decided;
    } verdict_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [LEN_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    sliding_median_spike_detector dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    verdict_t    spike_verdicts[$];
    logic [7:0]  win_ring[WINDOW_MAX];
    int unsigned win_hist[VALUE_LEVELS];
    int unsigned win_len;
    int unsigned win_fill;
    int unsigned win_ptr;
    logic [31:0] alert_total;

    int unsigned failures;
    int unsigned burst_left;
    bit          gaps_enabled;
    int unsigned rx_hold_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("sliding_median_spike_detector_test: errors");
        $finish;
    end

    function automatic void clear_window();
        foreach (win_hist[v]) win_hist[v] = 0;
        win_fill    = 0;
        win_ptr     = 0;
        alert_total = '0;
    endfunction

    function automatic int unsigned sorted_value(input int unsigned rank);
        int unsigned acc;
        acc = 0;
        for (int v = 0; v < VALUE_LEVELS; v++) begin
            acc += win_hist[v];
            if (acc > rank) return v;
        end
        return VALUE_LEVELS - 1;
    endfunction

    function automatic verdict_t judge_sample(input logic [7:0] sample, input logic restart);
        verdict_t    v;
        int unsigned pos;
        int unsigned med;
        if (restart) clear_window();
        v   = '0;
        pos = win_ptr % WINDOW_MAX;
        if (win_fill >= win_len) begin
            v.decided = 1'b1;
            if (win_len % 2 == 0) begin
                med = sorted_value(win_len / 2) + sorted_value(win_len / 2 - 1);
            end else begin
                med = 2 * sorted_value(win_len / 2);
            end
            v.med2 = med[MED_W-1:0];
            if (sample >= med) begin
                v.alert = 1'b1;
                if (alert_total != 32'hFFFF_FFFF) alert_total++;
            end
            if (win_hist[win_ring[pos]] != 0) win_hist[win_ring[pos]]--;
        end else begin
            win_fill++;
        end
        win_ring[pos] = sample;
        win_hist[sample]++;
        pos++;
        win_ptr = (pos >= win_len) ? 0 : pos;
        v.count = alert_total;
        return v;
    endfunction

    task automatic send_sample(input logic [7:0] sample, input logic restart);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_enabled && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 300 : 20))
                    @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        spike_verdicts.insert(spike_verdicts.size(), judge_sample(sample, restart));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (spike_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_window(input logic [LEN_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (len == 0) win_len = 1;
        else if (len > WINDOW_MAX) win_len = WINDOW_MAX;
        else win_len = len;
        clear_window();
        burst_left = 0;
    endtask

    // The window length is left at its reset value for the first group of samples.
    task automatic test_directed_windows();
        logic [7:0] seq1[10] = '{8'd0, 8'd0, 8'd255, 8'd127, 8'd254, 8'd127, 8'd253,
                                 8'd10, 8'd20, 8'd19};
        logic [7:0] seq4[6]  = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd4};
        logic [7:0] seq3[5]  = '{8'd100, 8'd50, 8'd200, 8'd199, 8'd200};
        foreach (seq1[i]) send_sample(seq1[i], i == 7);
        set_window(11'd4);
        foreach (seq4[i]) send_sample(seq4[i], 1'b0);
        set_window(11'd3);
        foreach (seq3[i]) send_sample(seq3[i], 1'b0);
        send_sample(8'd255, 1'b1);
    endtask

    task automatic test_window_extremes();
        set_window(11'd0);
        repeat (6) send_sample(8'($urandom_range(0, 255)), 1'b0);
        set_window(11'd2047);
        repeat (40) send_sample(8'($urandom_range(0, 255)), 1'b0);
        set_window(11'd2);
        repeat (8) send_sample(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_output_backpressure();
        set_window(11'd5);
        gaps_enabled = 1'b0;
        repeat (6) send_sample(8'($urandom_range(0, 255)), 1'b0);
        rx_hold_left = 3000;
        repeat (12) send_sample(8'($urandom_range(0, 255)), 1'b0);
        drain();
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_spikes();
        int unsigned sent;
        int unsigned run;
        int unsigned base;
        int unsigned pick;
        int unsigned value;
        sent = 0;
        while (sent < 820) begin
            pick = $urandom_range(0, 9);
            set_window(LEN_W'((pick == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16)));
            gaps_enabled = ($urandom_range(0, 2) != 0);
            run  = $urandom_range(30, 110);
            base = $urandom_range(0, 100);
            repeat (run) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    value = $urandom_range(0, 255);
                end else if (pick < 20) begin
                    value = 2 * base + $urandom_range(0, base / 2 + 12);
                end else begin
                    value = base + $urandom_range(0, base / 4 + 3);
                end
                if (value > 255) value = 255;
                send_sample(8'(value), $urandom_range(0, 49) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned cyc;
        int unsigned style;
        cyc   = 0;
        style = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 700 == 0) style = $urandom_range(0, 3);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0, 1: m_tready <= 1'b1;
                    2: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_BITS-1:0];
            if (spike_verdicts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result transaction: decided=%0d alert=%0d %s%0d %s%0d",
                             got.decided, got.alert, "med2=", got.med2, "count=", got.count);
            end else begin
                want = spike_verdicts.pop_front();
                if (got.decided !== want.decided || got.alert !== want.alert ||
                        got.med2 !== want.med2 || got.count !== want.count) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch: expected decided=%0d alert=%0d med2=%0d count=%0d",
                                 want.decided, want.alert, want.med2, want.count);
                        $display("          got      decided=%0d alert=%0d med2=%0d count=%0d",
                                 got.decided, got.alert, got.med2, got.count);
                    end
                end
            end
        end
    end

    initial begin
        failures     = 0;
        burst_left   = 0;
        gaps_enabled = 1'b1;
        rx_hold_left = 0;
        win_len      = 1;
        clear_window();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_windows();
        test_window_extremes();
        test_output_backpressure();
        test_random_spikes();

        drain();
        repeat (300) @(posedge aclk);
        if (failures == 0 && spike_verdicts.size() == 0) begin
            $display("sliding_median_spike_detector_test: clean");
        end else begin
            $display("sliding_median_spike_detector_test: errors");
        end
        $finish;
    end

endmodule
